// ===== rtl/core/tcpo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpo_pkg
// Shared types and constants of the triangle closest-point block.
// ----------------------------------------------------------------------------
package tcpo_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int QUEUE_DEPTH     = 8;

	typedef enum logic [2:0] {
		RGN_VERT_A  = 3'd0,
		RGN_VERT_B  = 3'd1,
		RGN_EDGE_AB = 3'd2,
		RGN_VERT_C  = 3'd3,
		RGN_EDGE_AC = 3'd4,
		RGN_EDGE_BC = 3'd5,
		RGN_FACE    = 3'd6
	} region_t;

	typedef struct packed {
		region_t region;
		logic    degenerate;
	} tcpo_tag_t;

endpackage

// ===== rtl/core/tcpo_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpo_queue
// Short register FIFO between the classify front and the interpolate back.
// ----------------------------------------------------------------------------
module tcpo_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = tcpo_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	input  logic              pop,
	output logic [DATA_W-1:0] rdata,
	output logic              empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign rdata = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	// storage holds payload only
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/core/tcpo_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpo_front
// Edge vectors, exact dot products and cross terms, Voronoi region select.
// ----------------------------------------------------------------------------
module tcpo_front #(
	parameter int COORD_WIDTH = tcpo_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic [2:0][COORD_WIDTH-1:0]         a_in,
	input  logic [2:0][COORD_WIDTH-1:0]         b_in,
	input  logic [2:0][COORD_WIDTH-1:0]         c_in,
	output logic                                out_vld,
	output tcpo_pkg::tcpo_tag_t                 tag,
	output logic [2:0][COORD_WIDTH-1:0]         base,
	output logic [2:0][COORD_WIDTH:0]           v1,
	output logic [2:0][COORD_WIDTH:0]           v2,
	output logic [4*COORD_WIDTH+3:0]            num1,
	output logic [4*COORD_WIDTH+3:0]            den1,
	output logic [4*COORD_WIDTH+3:0]            num2,
	output logic [4*COORD_WIDTH+3:0]            den2
);

	localparam int W  = COORD_WIDTH;
	localparam int PW = 2 * W + 1;
	localparam int DW = 2 * W + 2;
	localparam int H  = DW / 2;
	localparam int HH = DW - H;
	localparam int VW = 2 * DW;

	typedef struct packed {
		logic d1_le0;
		logic d2_le0;
		logic d3_ge0;
		logic d4_le_d3;
		logic d1_ge0;
		logic d3_le0;
		logic d6_ge0;
		logic d5_le_d6;
		logic d2_ge0;
		logic d6_le0;
		logic d4_ge_d3;
		logic d5_ge_d6;
	} dflag_t;

	// vertex index 0 A, 1 B, 2 C; edge index 0 AB, 1 AC, 2 BC
	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [2:0][2:0][W-1:0]   vtx_s1, vtx_s2, vtx_s3, vtx_s4, vtx_s5, vtx_s6;
	logic [2:0][2:0][W:0]     edg_s1, edg_s2, edg_s3, edg_s4, edg_s5, edg_s6;
	logic [5:0][2:0][PW-1:0]  prod_s2;
	logic [5:0][DW-1:0]       d_s3;
	logic [5:0][DW-1:0]       mx, my;
	logic [5:0][2*HH-1:0]     pp_hh_s4;
	logic [5:0][HH+H:0]       pp_hl_s4;
	logic [5:0][HH+H:0]       pp_lh_s4;
	logic [5:0][2*H+1:0]      pp_ll_s4;
	dflag_t                   flg_s4, flg_s5, flg_s6;
	logic [DW-1:0]            d1_s4, d1_s5, d1_s6, d2_s4, d2_s5, d2_s6;
	logic [DW:0]              den_ab_s4, den_ab_s5, den_ab_s6;
	logic [DW:0]              den_ac_s4, den_ac_s5, den_ac_s6;
	logic [DW:0]              e1_s4, e1_s5, e1_s6, e2_s4;
	logic [DW+1:0]            den_bc_s5, den_bc_s6;
	logic [5:0][VW-1:0]       cross_s5;
	logic [VW-1:0]            va_s6, vb_s6, vc_s6;
	logic signed [VW-1:0]     den_face;

	// d1 = AB.-A, d2 = AC.-A, d3 = AB.-B, d4 = AC.-B, d5 = AB.-C, d6 = AC.-C
	always_comb begin
		mx[0] = d_s3[0]; my[0] = d_s3[3];
		mx[1] = d_s3[2]; my[1] = d_s3[1];
		mx[2] = d_s3[4]; my[2] = d_s3[1];
		mx[3] = d_s3[0]; my[3] = d_s3[5];
		mx[4] = d_s3[2]; my[4] = d_s3[5];
		mx[5] = d_s3[4]; my[5] = d_s3[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			vtx_s1[0][i] <= a_in[i];
			vtx_s1[1][i] <= b_in[i];
			vtx_s1[2][i] <= c_in[i];
			edg_s1[0][i] <= $signed(b_in[i]) - $signed(a_in[i]);
			edg_s1[1][i] <= $signed(c_in[i]) - $signed(a_in[i]);
			edg_s1[2][i] <= $signed(c_in[i]) - $signed(b_in[i]);
		end

		for (int v = 0; v < 3; v++) begin
			for (int e = 0; e < 2; e++) begin
				for (int i = 0; i < 3; i++) begin
					prod_s2[2*v+e][i] <= $signed(edg_s1[e][i]) * $signed(vtx_s1[v][i]);
				end
			end
		end

		for (int k = 0; k < 6; k++) begin
			d_s3[k] <= -($signed(prod_s2[k][0]) + $signed(prod_s2[k][1])
				+ $signed(prod_s2[k][2]));
		end

		// cross terms split into half-width partial products
		for (int j = 0; j < 6; j++) begin
			pp_hh_s4[j] <= $signed(mx[j][DW-1:H]) * $signed(my[j][DW-1:H]);
			pp_hl_s4[j] <= $signed(mx[j][DW-1:H]) * $signed({1'b0, my[j][H-1:0]});
			pp_lh_s4[j] <= $signed({1'b0, mx[j][H-1:0]}) * $signed(my[j][DW-1:H]);
			pp_ll_s4[j] <= $signed({1'b0, mx[j][H-1:0]}) * $signed({1'b0, my[j][H-1:0]});
		end
		flg_s4.d1_le0   <= $signed(d_s3[0]) <= 0;
		flg_s4.d2_le0   <= $signed(d_s3[1]) <= 0;
		flg_s4.d3_ge0   <= $signed(d_s3[2]) >= 0;
		flg_s4.d4_le_d3 <= $signed(d_s3[3]) <= $signed(d_s3[2]);
		flg_s4.d1_ge0   <= $signed(d_s3[0]) >= 0;
		flg_s4.d3_le0   <= $signed(d_s3[2]) <= 0;
		flg_s4.d6_ge0   <= $signed(d_s3[5]) >= 0;
		flg_s4.d5_le_d6 <= $signed(d_s3[4]) <= $signed(d_s3[5]);
		flg_s4.d2_ge0   <= $signed(d_s3[1]) >= 0;
		flg_s4.d6_le0   <= $signed(d_s3[5]) <= 0;
		flg_s4.d4_ge_d3 <= $signed(d_s3[3]) >= $signed(d_s3[2]);
		flg_s4.d5_ge_d6 <= $signed(d_s3[4]) >= $signed(d_s3[5]);
		d1_s4     <= d_s3[0];
		d2_s4     <= d_s3[1];
		den_ab_s4 <= $signed(d_s3[0]) - $signed(d_s3[2]);
		den_ac_s4 <= $signed(d_s3[1]) - $signed(d_s3[5]);
		e1_s4     <= $signed(d_s3[3]) - $signed(d_s3[2]);
		e2_s4     <= $signed(d_s3[4]) - $signed(d_s3[5]);

		for (int j = 0; j < 6; j++) begin
			cross_s5[j] <= ($signed(pp_hh_s4[j]) <<< (2 * H))
				+ ($signed(pp_hl_s4[j]) <<< H)
				+ ($signed(pp_lh_s4[j]) <<< H)
				+ $signed(pp_ll_s4[j]);
		end
		flg_s5    <= flg_s4;
		d1_s5     <= d1_s4;
		d2_s5     <= d2_s4;
		den_ab_s5 <= den_ab_s4;
		den_ac_s5 <= den_ac_s4;
		e1_s5     <= e1_s4;
		den_bc_s5 <= $signed(e1_s4) + $signed(e2_s4);

		vc_s6     <= $signed(cross_s5[0]) - $signed(cross_s5[1]);
		vb_s6     <= $signed(cross_s5[2]) - $signed(cross_s5[3]);
		va_s6     <= $signed(cross_s5[4]) - $signed(cross_s5[5]);
		flg_s6    <= flg_s5;
		d1_s6     <= d1_s5;
		d2_s6     <= d2_s5;
		den_ab_s6 <= den_ab_s5;
		den_ac_s6 <= den_ac_s5;
		e1_s6     <= e1_s5;
		den_bc_s6 <= den_bc_s5;

		vtx_s2 <= vtx_s1; vtx_s3 <= vtx_s2; vtx_s4 <= vtx_s3;
		vtx_s5 <= vtx_s4; vtx_s6 <= vtx_s5;
		edg_s2 <= edg_s1; edg_s3 <= edg_s2; edg_s4 <= edg_s3;
		edg_s5 <= edg_s4; edg_s6 <= edg_s5;
	end

	assign den_face = $signed(va_s6) + $signed(vb_s6) + $signed(vc_s6);
	assign out_vld  = vld_s6;

	// region tests in priority order; unused factors stay zero
	always_comb begin
		tag.region     = tcpo_pkg::RGN_FACE;
		tag.degenerate = 1'b0;
		base = vtx_s6[0];
		v1   = '0;
		v2   = '0;
		num1 = '0;
		den1 = '0;
		num2 = '0;
		den2 = '0;
		if (flg_s6.d1_le0 && flg_s6.d2_le0) begin
			tag.region = tcpo_pkg::RGN_VERT_A;
		end else if (flg_s6.d3_ge0 && flg_s6.d4_le_d3) begin
			tag.region = tcpo_pkg::RGN_VERT_B;
			base = vtx_s6[1];
		end else if ($signed(vc_s6) <= 0 && flg_s6.d1_ge0 && flg_s6.d3_le0) begin
			tag.region = tcpo_pkg::RGN_EDGE_AB;
			v1   = edg_s6[0];
			num1 = $signed(d1_s6);
			den1 = $signed(den_ab_s6);
		end else if (flg_s6.d6_ge0 && flg_s6.d5_le_d6) begin
			tag.region = tcpo_pkg::RGN_VERT_C;
			base = vtx_s6[2];
		end else if ($signed(vb_s6) <= 0 && flg_s6.d2_ge0 && flg_s6.d6_le0) begin
			tag.region = tcpo_pkg::RGN_EDGE_AC;
			v1   = edg_s6[1];
			num1 = $signed(d2_s6);
			den1 = $signed(den_ac_s6);
		end else if ($signed(va_s6) <= 0 && flg_s6.d4_ge_d3 && flg_s6.d5_ge_d6) begin
			tag.region = tcpo_pkg::RGN_EDGE_BC;
			base = vtx_s6[1];
			v1   = edg_s6[2];
			num1 = $signed(e1_s6);
			den1 = $signed(den_bc_s6);
		end else if (den_face <= 0) begin
			tag.degenerate = 1'b1;
		end else begin
			v1   = edg_s6[0];
			v2   = edg_s6[1];
			num1 = vb_s6;
			num2 = vc_s6;
			den1 = den_face;
			den2 = den_face;
		end
	end

endmodule

// ===== rtl/core/tcpo_frac_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpo_frac_div
// Pipelined restoring divider: num/den as a clamped unsigned fraction.
// ----------------------------------------------------------------------------
module tcpo_frac_div #(
	parameter int COORD_WIDTH = tcpo_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = tcpo_pkg::FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [4*COORD_WIDTH+3:0] num,
	input  logic [4*COORD_WIDTH+3:0] den,
	output logic [FRAC_BITS:0]       quo
);

	localparam int F  = FRAC_BITS;
	localparam int VW = 4 * COORD_WIDTH + 4;

	logic          zero_s [F+1];
	logic          one_s  [F+1];
	logic [VW-1:0] rem_s  [F+1];
	logic [VW-1:0] den_s  [F+1];
	logic [F-1:0]  quo_s  [F+1];

	// entry stage: spot the clamped cases
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= ($signed(num) <= 0) || ($signed(den) <= 0);
			one_s[0]  <= $signed(num) >= $signed(den);
			rem_s[0]  <= num;
			den_s[0]  <= den;
			quo_s[0]  <= '0;
		end
	end

	// one quotient bit per stage
	for (genvar k = 1; k <= F; k++) begin : g_iter
		logic [VW:0] dbl;
		logic [VW:0] diff;
		logic        ge;

		assign dbl  = {rem_s[k-1], 1'b0};
		assign diff = dbl - {1'b0, den_s[k-1]};
		assign ge   = dbl >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[k] <= zero_s[k-1];
				one_s[k]  <= one_s[k-1];
				den_s[k]  <= den_s[k-1];
				rem_s[k]  <= ge ? diff[VW-1:0] : dbl[VW-1:0];
				quo_s[k]  <= {quo_s[k-1][F-2:0], ge};
			end
		end
	end

	always_comb begin
		if (zero_s[F]) begin
			quo = '0;
		end else if (one_s[F]) begin
			quo = {1'b1, {F{1'b0}}};
		end else begin
			quo = {1'b0, quo_s[F]};
		end
	end

endmodule

// ===== rtl/core/tcpo_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpo_back
// Divide, interpolate, round and saturate; drive the output register.
// ----------------------------------------------------------------------------
module tcpo_back #(
	parameter int COORD_WIDTH = tcpo_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = tcpo_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	output logic                        q_pop,
	input  tcpo_pkg::tcpo_tag_t         q_tag,
	input  logic [2:0][COORD_WIDTH-1:0] q_base,
	input  logic [2:0][COORD_WIDTH:0]   q_v1,
	input  logic [2:0][COORD_WIDTH:0]   q_v2,
	input  logic [4*COORD_WIDTH+3:0]    q_num1,
	input  logic [4*COORD_WIDTH+3:0]    q_den1,
	input  logic [4*COORD_WIDTH+3:0]    q_num2,
	input  logic [4*COORD_WIDTH+3:0]    q_den2,
	output logic                        out_vld,
	input  logic                        out_rdy,
	output tcpo_pkg::tcpo_tag_t         out_tag,
	output logic [2:0][COORD_WIDTH-1:0] out_p
);

	localparam int W  = COORD_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int VW = 4 * W + 4;
	localparam int SW = F + W + 3;
	localparam int L  = F + 1;
	localparam logic signed [SW-1:0] RND = SW'(1) << (F - 1);
	localparam logic signed [SW:0] SAT_HI = {{(SW - W + 2){1'b0}}, {(W - 1){1'b1}}};
	localparam logic signed [SW:0] SAT_LO = {{(SW - W + 2){1'b1}}, {(W - 1){1'b0}}};

	logic                en;
	logic                vld_s1;
	tcpo_pkg::tcpo_tag_t tag_s1;
	logic [2:0][W-1:0]   base_s1;
	logic [2:0][W:0]     v1_s1, v2_s1;
	logic [VW-1:0]       num1_s1, den1_s1, num2_s1, den2_s1;

	logic                vld_d  [L];
	tcpo_pkg::tcpo_tag_t tag_d  [L];
	logic [2:0][W-1:0]   base_d [L];
	logic [2:0][W:0]     v1_d   [L];
	logic [2:0][W:0]     v2_d   [L];
	logic [F:0]          t1, t2;

	logic                vld_sm, vld_sa;
	tcpo_pkg::tcpo_tag_t tag_sm, tag_sa;
	logic [2:0][W-1:0]   base_sm, base_sa;
	logic [2:0][SW-1:0]  m1_sm, m2_sm, acc_sa;
	logic signed [SW:0]  pnt [3];

	logic                out_vld_q;

	// the whole back half holds while a result waits at the output
	assign en      = !out_vld_q || out_rdy;
	assign q_pop   = en && !q_empty;
	assign out_vld = out_vld_q;

	tcpo_frac_div #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_div1 (
		.clk (clk),
		.en  (en),
		.num (num1_s1),
		.den (den1_s1),
		.quo (t1)
	);

	tcpo_frac_div #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_div2 (
		.clk (clk),
		.en  (en),
		.num (num2_s1),
		.den (den2_s1),
		.quo (t2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_sm    <= 1'b0;
			vld_sa    <= 1'b0;
			out_vld_q <= 1'b0;
			for (int k = 0; k < L; k++) begin
				vld_d[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s1   <= !q_empty;
			vld_d[0] <= vld_s1;
			for (int k = 1; k < L; k++) begin
				vld_d[k] <= vld_d[k-1];
			end
			vld_sm    <= vld_d[L-1];
			vld_sa    <= vld_sm;
			out_vld_q <= vld_sa;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pnt[i] = $signed(base_sa[i]) + ($signed(acc_sa[i]) >>> F);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1  <= q_tag;
			base_s1 <= q_base;
			v1_s1   <= q_v1;
			v2_s1   <= q_v2;
			num1_s1 <= q_num1;
			den1_s1 <= q_den1;
			num2_s1 <= q_num2;
			den2_s1 <= q_den2;

			tag_d[0]  <= tag_s1;
			base_d[0] <= base_s1;
			v1_d[0]   <= v1_s1;
			v2_d[0]   <= v2_s1;
			for (int k = 1; k < L; k++) begin
				tag_d[k]  <= tag_d[k-1];
				base_d[k] <= base_d[k-1];
				v1_d[k]   <= v1_d[k-1];
				v2_d[k]   <= v2_d[k-1];
			end

			tag_sm  <= tag_d[L-1];
			base_sm <= base_d[L-1];
			for (int i = 0; i < 3; i++) begin
				m1_sm[i] <= $signed({1'b0, t1}) * $signed(v1_d[L-1][i]);
				m2_sm[i] <= $signed({1'b0, t2}) * $signed(v2_d[L-1][i]);
			end

			tag_sa  <= tag_sm;
			base_sa <= base_sm;
			for (int i = 0; i < 3; i++) begin
				acc_sa[i] <= $signed(m1_sm[i]) + $signed(m2_sm[i]) + RND;
			end

			out_tag <= tag_sa;
			for (int i = 0; i < 3; i++) begin
				if (pnt[i] > SAT_HI) begin
					out_p[i] <= SAT_HI[W-1:0];
				end else if (pnt[i] < SAT_LO) begin
					out_p[i] <= SAT_LO[W-1:0];
				end else begin
					out_p[i] <= pnt[i][W-1:0];
				end
			end
		end
	end

endmodule

// ===== rtl/core/triangle_closest_point_to_origin.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_closest_point_to_origin
// Closest point of a 3D triangle to the origin, with its Voronoi region.
// ----------------------------------------------------------------------------
// Usage
//   Input channel s_axis: one word is one triangle, vertices A, B, C as
//   signed fixed point coordinates. Output channel m_axis: one word per
//   triangle, in input order: the closest point (rounded, saturated), the
//   region code and the degenerate-face flag.
//   Throughput: one triangle per clock while m_axis_tready is high.
//   The front computes exact dot products and region select and feeds a
//   short queue; the back half spends FRAC_BITS + 1 stages in the
//   restoring dividers (one quotient bit per stage), then multiply,
//   round and saturate into the output register.
//   Stall: when m_axis_tready is low the back half holds; the front keeps
//   running into the queue, and s_axis_tready drops once every queue slot
//   is spoken for by a triangle in flight.
//   Reset: arst_n clears all valid state and the slot count; no words are
//   in flight afterwards and s_axis_tready stays high through reset.
// ----------------------------------------------------------------------------
module triangle_closest_point_to_origin #(
	parameter int COORD_WIDTH = tcpo_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = tcpo_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// ax, ay, az, bx, by_coord, bz, cx, cy, cz from bit 0 up, zero padded
	input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// px, py, pz, region, degenerate from bit 0 up, zero padded
	output logic [((3*COORD_WIDTH+11)/8)*8-1:0]    m_axis_tdata
);

	localparam int W     = COORD_WIDTH;
	localparam int VW    = 4 * W + 4;
	localparam int TW    = $bits(tcpo_pkg::tcpo_tag_t);
	localparam int QW    = TW + 3 * W + 6 * (W + 1) + 4 * VW;
	localparam int OW    = ((3 * W + 11) / 8) * 8;
	localparam int DEPTH = tcpo_pkg::QUEUE_DEPTH;
	localparam int NW    = $clog2(DEPTH + 1);

	logic                s_acc;
	logic [2:0][W-1:0]   a_in, b_in, c_in;

	logic                f_vld;
	tcpo_pkg::tcpo_tag_t f_tag;
	logic [2:0][W-1:0]   f_base;
	logic [2:0][W:0]     f_v1, f_v2;
	logic [VW-1:0]       f_num1, f_den1, f_num2, f_den2;

	logic [QW-1:0]       q_wdata, q_rdata;
	logic                q_empty, q_pop;

	tcpo_pkg::tcpo_tag_t b_tag;
	logic [2:0][W-1:0]   b_base;
	logic [2:0][W:0]     b_v1, b_v2;
	logic [VW-1:0]       b_num1, b_den1, b_num2, b_den2;

	tcpo_pkg::tcpo_tag_t o_tag;
	logic [2:0][W-1:0]   o_p;

	// slots taken: triangles accepted and not yet popped from the queue
	logic [NW-1:0]       slots_q;

	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (slots_q < NW'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= '0;
		end else begin
			slots_q <= slots_q + NW'(s_acc) - NW'(q_pop);
		end
	end

	// split the input word into vertices
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_in[i] = s_axis_tdata[i*W +: W];
			b_in[i] = s_axis_tdata[(3+i)*W +: W];
			c_in[i] = s_axis_tdata[(6+i)*W +: W];
		end
	end

	tcpo_front #(.COORD_WIDTH(W)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (s_acc),
		.a_in    (a_in),
		.b_in    (b_in),
		.c_in    (c_in),
		.out_vld (f_vld),
		.tag     (f_tag),
		.base    (f_base),
		.v1      (f_v1),
		.v2      (f_v2),
		.num1    (f_num1),
		.den1    (f_den1),
		.num2    (f_num2),
		.den2    (f_den2)
	);

	// the slot count keeps the queue from overflowing
	assign q_wdata = {f_tag, f_base, f_v1, f_v2, f_num1, f_den1, f_num2, f_den2};

	tcpo_queue #(.DATA_W(QW), .DEPTH(DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_vld),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign {b_tag, b_base, b_v1, b_v2, b_num1, b_den1, b_num2, b_den2} = q_rdata;

	tcpo_back #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_tag   (b_tag),
		.q_base  (b_base),
		.q_v1    (b_v1),
		.q_v2    (b_v2),
		.q_num1  (b_num1),
		.q_den1  (b_den1),
		.q_num2  (b_num2),
		.q_den2  (b_den2),
		.out_vld (m_axis_tvalid),
		.out_rdy (m_axis_tready),
		.out_tag (o_tag),
		.out_p   (o_p)
	);

	// pack the result word, lowest field first
	assign m_axis_tdata = OW'({o_tag.degenerate, o_tag.region, o_p[2], o_p[1], o_p[0]});

endmodule

// ===== rtl/core/tcpo_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpo_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tcpo_checker #(
	parameter int COORD_WIDTH = tcpo_pkg::COORD_WIDTH_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [((3*COORD_WIDTH+11)/8)*8-1:0] m_axis_tdata
);

	localparam int RL = 3 * COORD_WIDTH;

	logic [2:0] region;
	logic       degenerate;

	assign region     = m_axis_tdata[RL+2:RL];
	assign degenerate = m_axis_tdata[RL+3];

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	a_region_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> region != 3'd7)
		else $error("region code out of range");

	a_degen_face: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && degenerate |-> region == tcpo_pkg::RGN_FACE)
		else $error("degenerate flag outside face region");

endmodule

bind triangle_closest_point_to_origin tcpo_checker #(.COORD_WIDTH(COORD_WIDTH)) u_chk (.*);
